### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the LCD text renderer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define GLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GLCD_ASSERT(lbl, prop, msg)
`define GLCD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/glcd_pkg.sv
// ---------------------------------------------------------------------------
// glcd_pkg
// Constants and types shared by the character cell to LCD command renderer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package glcd_pkg;

  localparam int CELLS_PER_LINE = 21;
  localparam int GLYPH_WIDTH    = 6;
  localparam int HALF_WIDTH     = 64;
  localparam int FONT_ROWS      = 128;
  localparam int GLYPH_BITS     = 8 * GLYPH_WIDTH;

  localparam logic [7:0] PAGE_SET_OP   = 8'hB8;
  localparam logic [7:0] COL_SET_OP    = 8'h40;
  localparam logic [5:0] CUR_COL_RESET = 6'd1;

  // Screen column of the first glyph column of a character (0..127).
  typedef logic [6:0] scr_col_t;

  typedef enum logic [1:0] {
    WK_PAGE,
    WK_COL,
    WK_DATA
  } word_kind_t;

  typedef struct packed {
    logic [2:0] page;
    scr_col_t   col;
    logic       inv;
  } glcd_item_t;

endpackage

`default_nettype wire

### hdl/glcd_font_rom.sv
// ---------------------------------------------------------------------------
// glcd_font_rom
// 128-entry 6x8 font, one whole glyph per word, synchronous read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glcd_font_rom (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [6:0]                     rd_addr,
  output logic      [glcd_pkg::GLYPH_BITS-1:0] rd_data
);
  import glcd_pkg::*;

  logic [GLYPH_BITS-1:0] rom_word;
  logic [GLYPH_BITS-1:0] rd_data_r;

  // Leftmost glyph column sits in the top byte.
  always_comb begin
    case (rd_addr)
      7'd33:   rom_word = 48'h00_00_00_5F_00_00;
      7'd34:   rom_word = 48'h00_00_07_00_07_00;
      7'd35:   rom_word = 48'h00_14_7F_14_7F_14;
      7'd36:   rom_word = 48'h00_24_2A_7F_2A_12;
      7'd37:   rom_word = 48'h00_23_13_08_64_62;
      7'd38:   rom_word = 48'h00_36_49_55_22_50;
      7'd39:   rom_word = 48'h00_00_05_03_00_00;
      7'd40:   rom_word = 48'h00_00_1C_22_41_00;
      7'd41:   rom_word = 48'h00_00_41_22_1C_00;
      7'd42:   rom_word = 48'h00_08_2A_1C_2A_08;
      7'd43:   rom_word = 48'h00_08_08_3E_08_08;
      7'd45:   rom_word = 48'h00_08_08_08_08_08;
      7'd46:   rom_word = 48'h00_00_30_30_00_00;
      7'd47:   rom_word = 48'h00_20_10_08_04_02;
      7'd48:   rom_word = 48'h00_3E_51_49_45_3E;
      7'd49:   rom_word = 48'h00_00_42_7F_40_00;
      7'd50:   rom_word = 48'h00_42_61_51_49_46;
      7'd51:   rom_word = 48'h00_21_41_45_4B_31;
      7'd52:   rom_word = 48'h00_18_14_12_7F_10;
      7'd53:   rom_word = 48'h00_27_45_45_45_39;
      7'd54:   rom_word = 48'h00_3C_4A_49_49_30;
      7'd55:   rom_word = 48'h00_01_71_09_05_03;
      7'd56:   rom_word = 48'h00_36_49_49_49_36;
      7'd57:   rom_word = 48'h00_06_49_49_29_1E;
      7'd58:   rom_word = 48'h00_00_36_36_00_00;
      7'd59:   rom_word = 48'h00_00_56_36_00_00;
      7'd60:   rom_word = 48'h00_00_08_14_22_41;
      7'd61:   rom_word = 48'h00_14_14_14_14_14;
      7'd62:   rom_word = 48'h00_41_22_14_08_00;
      7'd63:   rom_word = 48'h00_02_01_51_09_06;
      7'd64:   rom_word = 48'h00_32_49_79_41_3E;
      7'd65:   rom_word = 48'h00_7E_11_11_11_7E;
      7'd66:   rom_word = 48'h00_7F_49_49_49_36;
      7'd67:   rom_word = 48'h00_3E_41_41_41_22;
      7'd68:   rom_word = 48'h00_7F_41_41_22_1C;
      7'd69:   rom_word = 48'h00_7F_49_49_49_41;
      7'd70:   rom_word = 48'h00_7F_09_09_01_01;
      7'd71:   rom_word = 48'h00_3E_41_41_51_32;
      7'd72:   rom_word = 48'h00_7F_08_08_08_7F;
      7'd73:   rom_word = 48'h00_00_41_7F_41_00;
      7'd74:   rom_word = 48'h00_20_40_41_3F_01;
      7'd75:   rom_word = 48'h00_7F_08_14_22_41;
      7'd76:   rom_word = 48'h00_7F_40_40_40_40;
      7'd77:   rom_word = 48'h00_7F_02_04_02_7F;
      7'd78:   rom_word = 48'h00_7F_04_08_10_7F;
      7'd79:   rom_word = 48'h00_3E_41_41_41_3E;
      7'd80:   rom_word = 48'h00_7F_09_09_09_06;
      7'd81:   rom_word = 48'h00_3E_41_51_21_5E;
      7'd82:   rom_word = 48'h00_7F_09_19_29_46;
      7'd83:   rom_word = 48'h00_46_49_49_49_31;
      7'd84:   rom_word = 48'h00_01_01_7F_01_01;
      7'd85:   rom_word = 48'h00_3F_40_40_40_3F;
      7'd86:   rom_word = 48'h00_1F_20_40_20_1F;
      7'd87:   rom_word = 48'h00_7F_20_18_20_7F;
      7'd88:   rom_word = 48'h00_63_14_08_14_63;
      7'd89:   rom_word = 48'h00_03_04_78_04_03;
      7'd90:   rom_word = 48'h00_61_51_49_45_43;
      7'd91:   rom_word = 48'h00_00_00_7F_41_41;
      7'd92:   rom_word = 48'h00_02_04_08_10_20;
      7'd93:   rom_word = 48'h00_41_41_7F_00_00;
      7'd94:   rom_word = 48'h00_04_02_01_02_04;
      7'd95:   rom_word = 48'h00_40_40_40_40_40;
      7'd96:   rom_word = 48'h00_00_01_02_04_00;
      7'd97:   rom_word = 48'h00_20_54_54_54_78;
      7'd98:   rom_word = 48'h00_7F_48_44_44_38;
      7'd99:   rom_word = 48'h00_38_44_44_44_20;
      7'd100:  rom_word = 48'h00_38_44_44_48_7F;
      7'd101:  rom_word = 48'h00_38_54_54_54_18;
      7'd102:  rom_word = 48'h00_08_7E_09_01_02;
      7'd103:  rom_word = 48'h00_08_14_54_54_3C;
      7'd104:  rom_word = 48'h00_7F_08_04_04_78;
      7'd105:  rom_word = 48'h00_00_44_7D_40_00;
      7'd106:  rom_word = 48'h00_20_40_44_3D_00;
      7'd107:  rom_word = 48'h00_00_7F_10_28_44;
      7'd108:  rom_word = 48'h00_00_41_7F_40_00;
      7'd109:  rom_word = 48'h00_7C_04_18_04_78;
      7'd110:  rom_word = 48'h00_7C_08_04_04_78;
      7'd111:  rom_word = 48'h00_38_44_44_44_38;
      7'd112:  rom_word = 48'h00_7C_14_14_14_08;
      7'd113:  rom_word = 48'h00_08_14_14_18_7C;
      7'd114:  rom_word = 48'h00_7C_08_04_04_08;
      7'd115:  rom_word = 48'h00_48_54_54_54_20;
      7'd116:  rom_word = 48'h00_04_3F_44_40_20;
      7'd117:  rom_word = 48'h00_3C_40_40_20_7C;
      7'd118:  rom_word = 48'h00_1C_20_40_20_1C;
      7'd119:  rom_word = 48'h00_3C_40_30_40_3C;
      7'd120:  rom_word = 48'h00_44_28_10_28_44;
      7'd121:  rom_word = 48'h00_0C_50_50_50_3C;
      7'd122:  rom_word = 48'h00_44_64_54_4C_44;
      7'd123:  rom_word = 48'h00_00_08_36_41_00;
      7'd124:  rom_word = 48'h00_00_00_7F_00_00;
      7'd125:  rom_word = 48'h00_00_41_36_08_00;
      default: rom_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_word;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/glcd_emitter.sv
// ---------------------------------------------------------------------------
// glcd_emitter
// Walks the six glyph columns of one character, tracks the controller
// cursor and issues page-set, column-set and data words into an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module glcd_emitter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            item_valid,
  input  wire glcd_pkg::glcd_item_t            item,
  input  wire logic [glcd_pkg::GLYPH_BITS-1:0] glyph,
  output logic                                 item_take,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_right_half,
  output logic                                 out_is_data,
  output logic [7:0]                           out_lcd_byte,
  output logic                                 out_last
);
  import glcd_pkg::*;

  // Character being rendered.
  logic                  w_valid_r, w_valid_nxt;
  logic [2:0]            w_page_r, w_page_nxt;
  scr_col_t              w_col_r, w_col_nxt;
  logic                  w_inv_r, w_inv_nxt;
  logic [GLYPH_BITS-1:0] w_glyph_r, w_glyph_nxt;
  logic [2:0]            w_idx_r, w_idx_nxt;

  // Controller cursor.
  logic       cur_side_r, cur_side_nxt;
  logic [2:0] cur_page_r, cur_page_nxt;
  logic [5:0] cur_column_r, cur_column_nxt;
  logic       force_col_r, force_col_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       out_right_half_r, out_right_half_nxt;
  logic       out_is_data_r, out_is_data_nxt;
  logic [7:0] out_lcd_byte_r, out_lcd_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic       side;
  logic [5:0] low;
  word_kind_t kind;
  logic       out_ok;
  logic       issue;
  logic       char_end;
  logic [7:0] word_byte;

  assign side     = (w_col_r >= scr_col_t'(HALF_WIDTH));
  assign low      = w_col_r[5:0];
  assign out_ok   = !out_valid_r || !out_stall;
  assign issue    = w_valid_r && out_ok;

  // A page-set always drags a column-set behind it, even if the column matches.
  always_comb begin
    if ((side != cur_side_r) || (w_page_r != cur_page_r)) begin
      kind = WK_PAGE;
    end else if (force_col_r || (low != cur_column_r)) begin
      kind = WK_COL;
    end else begin
      kind = WK_DATA;
    end
  end

  assign char_end  = (kind == WK_DATA) && (w_idx_r == 3'(GLYPH_WIDTH - 1));
  assign item_take = item_valid && (!w_valid_r || (issue && char_end));

  always_comb begin
    unique case (kind)
      WK_PAGE: word_byte = PAGE_SET_OP | {5'b0, w_page_r};
      WK_COL:  word_byte = COL_SET_OP | {2'b0, low};
      WK_DATA: word_byte = w_glyph_r[GLYPH_BITS-1 -: 8] ^ {8{w_inv_r}};
      default: word_byte = w_glyph_r[GLYPH_BITS-1 -: 8] ^ {8{w_inv_r}};
    endcase
  end

  always_comb begin
    w_valid_nxt    = w_valid_r;
    w_page_nxt     = w_page_r;
    w_col_nxt      = w_col_r;
    w_inv_nxt      = w_inv_r;
    w_glyph_nxt    = w_glyph_r;
    w_idx_nxt      = w_idx_r;
    cur_side_nxt   = cur_side_r;
    cur_page_nxt   = cur_page_r;
    cur_column_nxt = cur_column_r;
    force_col_nxt  = force_col_r;

    if (issue) begin
      case (kind)
        WK_PAGE: begin
          cur_side_nxt  = side;
          cur_page_nxt  = w_page_r;
          force_col_nxt = 1'b1;
        end
        WK_COL: begin
          cur_column_nxt = low;
          force_col_nxt  = 1'b0;
        end
        default: begin
          cur_column_nxt = low + 6'd1;
          w_col_nxt      = w_col_r + scr_col_t'(1);
          w_idx_nxt      = w_idx_r + 3'd1;
          w_glyph_nxt    = w_glyph_r << 8;
          if (char_end) begin
            w_valid_nxt = 1'b0;
          end
        end
      endcase
    end

    if (item_take) begin
      w_valid_nxt = 1'b1;
      w_page_nxt  = item.page;
      w_col_nxt   = item.col;
      w_inv_nxt   = item.inv;
      w_glyph_nxt = glyph;
      w_idx_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt      = out_valid_r;
    out_right_half_nxt = out_right_half_r;
    out_is_data_nxt    = out_is_data_r;
    out_lcd_byte_nxt   = out_lcd_byte_r;
    out_last_nxt       = out_last_r;
    if (out_ok) begin
      out_valid_nxt      = w_valid_r;
      out_right_half_nxt = side;
      out_is_data_nxt    = (kind == WK_DATA);
      out_lcd_byte_nxt   = word_byte;
      out_last_nxt       = char_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r    <= 1'b0;
      cur_side_r   <= 1'b0;
      cur_page_r   <= '0;
      cur_column_r <= CUR_COL_RESET;
      force_col_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      w_valid_r    <= w_valid_nxt;
      cur_side_r   <= cur_side_nxt;
      cur_page_r   <= cur_page_nxt;
      cur_column_r <= cur_column_nxt;
      force_col_r  <= force_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_page_r         <= w_page_nxt;
    w_col_r          <= w_col_nxt;
    w_inv_r          <= w_inv_nxt;
    w_glyph_r        <= w_glyph_nxt;
    w_idx_r          <= w_idx_nxt;
    out_right_half_r <= out_right_half_nxt;
    out_is_data_r    <= out_is_data_nxt;
    out_lcd_byte_r   <= out_lcd_byte_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_right_half = out_right_half_r;
  assign out_is_data    = out_is_data_r;
  assign out_lcd_byte   = out_lcd_byte_r;
  assign out_last       = out_last_r;

  `GLCD_ASSERT(a_last_is_data, out_valid_r && out_last_r |-> out_is_data_r, "last on a non-data word")
  `GLCD_ASSERT(a_page_then_col, out_valid_r && !out_stall && !out_is_data_r && (out_lcd_byte_r[7:3] == PAGE_SET_OP[7:3]) |=> out_valid_r && !out_is_data_r && (out_lcd_byte_r[7:6] == COL_SET_OP[7:6]), "page-set not followed by column-set")
  `GLCD_ASSERT(a_char_no_gap, out_valid_r && !out_stall && out_is_data_r && !out_last_r |=> out_valid_r, "gap inside a character")
  `GLCD_ASSERT(a_idx_range, w_valid_r |-> (w_idx_r <= 3'(GLYPH_WIDTH - 1)), "glyph column index out of range")

endmodule

`default_nettype wire

### hdl/glyph_to_lcd_command_stream.sv
// ---------------------------------------------------------------------------
// glyph_to_lcd_command_stream
// Renders character cell writes from a 6x8 font into the command word
// stream of a dual-controller 128x64 graphic LCD.
// ---------------------------------------------------------------------------
//
//   Channel  Ports                                              Direction
//   in       in_valid, in_stall, in_page, in_char_pos,          receive
//            in_char_code
//   out      out_valid, out_stall, out_right_half, out_is_data, send
//            out_lcd_byte, out_last
//
// A character gives 6 to 10 words at one word per cycle while out_stall is low:
// one data word per glyph column, plus a page-set and column-set when the side
// or page changes and a column-set when the column jumps. The output register
// sets that pace. A cell at or beyond the line length is taken and gives no word.
// One character waits in the input slot while another is emitted, so characters
// follow each other without a gap. Reset is synchronous and needs no clearing
// pass. out_stall holds the output register and, behind it, the emitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module glyph_to_lcd_command_stream (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_page,
  input  wire logic [4:0] in_char_pos,
  input  wire logic [7:0] in_char_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_right_half,
  output logic            out_is_data,
  output logic [7:0]      out_lcd_byte,
  output logic            out_last
);
  import glcd_pkg::*;

  logic                  p_valid_r, p_valid_nxt;
  glcd_item_t            p_item_r, p_item_nxt;
  logic                  in_accept;
  logic                  in_range;
  logic                  item_take;
  logic [GLYPH_BITS-1:0] glyph;

  assign in_range  = (in_char_pos < 5'(CELLS_PER_LINE));
  assign in_stall  = p_valid_r && !item_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_item_nxt  = p_item_r;
    if (item_take) begin
      p_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      p_valid_nxt     = in_range;
      p_item_nxt.page = in_page;
      p_item_nxt.col  = scr_col_t'(in_char_pos) * scr_col_t'(GLYPH_WIDTH) + scr_col_t'(1);
      p_item_nxt.inv  = in_char_code[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_item_r <= p_item_nxt;
  end

  // The glyph is fetched as the cell is taken and is ready by the next cycle.
  glcd_font_rom u_font_rom (
    .clk     (clk),
    .rd_en   (in_accept && in_range),
    .rd_addr (in_char_code[6:0]),
    .rd_data (glyph)
  );

  glcd_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (p_valid_r),
    .item           (p_item_r),
    .glyph          (glyph),
    .item_take      (item_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_right_half (out_right_half),
    .out_is_data    (out_is_data),
    .out_lcd_byte   (out_lcd_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
